>>> rtl/core/p10lu_pkg.sv
package p10lu_pkg;

  // Fixed field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned WORD_W  = 10;
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned CFG_W   = 12;
  localparam int unsigned PEND_W  = 9;
  localparam int unsigned PCNT_W  = 4;
  localparam int unsigned SHIFT_W = 3;

  // APB register map
  localparam int unsigned APB_DW = 32;
  localparam int unsigned APB_AW = 3;

  typedef enum logic [0:0] {
    REG_LINE_WIDTH   = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // Control from the frame logic to the bit accumulator
  typedef struct packed {
    logic step;   // byte consumed by an active frame
    logic clear;  // frame start: drop leftover bits first
  } acc_ctrl_t;

  // Word extracted from the current byte
  typedef struct packed {
    logic              word_ok;
    logic [WORD_W-1:0] word;
  } acc_out_t;

endpackage

>>> rtl/core/p10lu_bit_acc.sv
module p10lu_bit_acc (
  input  logic                           clk,
  input  logic                           rst_n,
  input  p10lu_pkg::acc_ctrl_t           ctrl,
  input  logic [p10lu_pkg::BYTE_W-1:0]   raw_byte,
  output p10lu_pkg::acc_out_t            acc_out
);
  import p10lu_pkg::*;

  logic [PEND_W-1:0]        pend_bits_r, pend_bits_nxt;
  logic [PCNT_W-1:0]        pend_cnt_r, pend_cnt_nxt;
  logic [PEND_W-1:0]        pb_cur;
  logic [PCNT_W-1:0]        pc_cur;
  logic [PCNT_W-1:0]        pc_less2;
  logic [PEND_W+BYTE_W-1:0] acc_w;
  logic [SHIFT_W-1:0]       sh;
  logic [PEND_W-1:0]        keep_mask;

  // Append the byte below the leftover bits; pull one 10-bit word once 10+ bits are held
  always_comb begin
    pb_cur    = ctrl.clear ? '0 : pend_bits_r;
    pc_cur    = ctrl.clear ? '0 : pend_cnt_r;
    acc_w     = {pb_cur, raw_byte};
    pc_less2  = pc_cur - PCNT_W'(2);
    sh        = pc_less2[SHIFT_W-1:0];
    keep_mask = (PEND_W'(1) << sh) - PEND_W'(1);
    acc_out.word = WORD_W'(acc_w >> sh);
    if (pc_cur < PCNT_W'(2)) begin
      acc_out.word_ok = 1'b0;
      pend_bits_nxt   = acc_w[PEND_W-1:0];
      pend_cnt_nxt    = pc_cur + PCNT_W'(BYTE_W);
    end else begin
      acc_out.word_ok = 1'b1;
      pend_bits_nxt   = acc_w[PEND_W-1:0] & keep_mask;
      pend_cnt_nxt    = pc_less2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
    end else if (ctrl.step) begin
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
    end
  end

endmodule

>>> rtl/core/packed_10bit_line_unpacker.sv
// Unpacks an MSB-first 10-bit word stream, one byte per request, into 8-bit pixels.
// A pixel shows on out_tvalid in the cycle after the byte that completes it is accepted.
// Throughput: one byte per cycle; in_tready stays high while the output register
// is empty or being drained, so stalls come only from out_tready.
// Reset (rst_n low, synchronous): registers back to 752 x 480, bit buffer empty,
// block idle until a byte with frame_start set.
module packed_10bit_line_unpacker #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048,
  parameter int unsigned SYNC_WORDS = 2
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [p10lu_pkg::BYTE_W-1:0]        in_tdata,   // [7:0] raw_byte
  input  logic                                in_tuser,   // [0] frame_start
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [p10lu_pkg::PIX_W-1:0]         out_tdata,  // [7:0] pixel
  output logic                                out_tlast,  // end_of_line
  output logic                                out_tuser,  // [0] end_of_frame
  // configuration
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [p10lu_pkg::APB_AW-1:0]        cfg_paddr,
  input  logic [p10lu_pkg::APB_DW-1:0]        cfg_pwdata,
  output logic [p10lu_pkg::APB_DW-1:0]        cfg_prdata,
  output logic                                cfg_pready
);
  import p10lu_pkg::*;

  localparam int unsigned WIL_W = $clog2(MAX_WIDTH + SYNC_WORDS + 1);
  localparam int unsigned LI_W  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned LW_W  = ((CFG_W > WIL_W) ? CFG_W : WIL_W) + 1;
  localparam int unsigned LH_W  = ((CFG_W > LI_W) ? CFG_W : LI_W) + 1;

  logic [CFG_W-1:0] line_width_r, frame_height_r;
  logic [WIL_W-1:0] wil_r, wil_nxt, wil_cur;
  logic [LI_W-1:0]  line_idx_r, line_idx_nxt, line_idx_cur;
  logic             frame_done_r, frame_done_nxt, frame_done_cur;
  logic             out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0] out_pix_r, out_pix_nxt;
  logic             out_eol_r, out_eol_nxt;
  logic             out_eof_r, out_eof_nxt;

  logic             in_acc, start, emit, cfg_wr;
  cfg_reg_t         cfg_sel;
  acc_ctrl_t        acc_ctrl;
  acc_out_t         acc_out;
  logic [LW_W-1:0]  width_ext, width_eff, line_last;
  logic [LH_W-1:0]  height_ext, height_eff, height_last;

  // APB register file
  assign cfg_pready = 1'b1;
  assign cfg_sel    = cfg_reg_t'(cfg_paddr[2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    unique case (cfg_sel)
      REG_LINE_WIDTH:   cfg_prdata = APB_DW'(line_width_r);
      REG_FRAME_HEIGHT: cfg_prdata = APB_DW'(frame_height_r);
      default:          cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r   <= CFG_W'(752);
      frame_height_r <= CFG_W'(480);
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_LINE_WIDTH:   line_width_r   <= cfg_pwdata[CFG_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective limits: zero acts as one, oversize clamps to the maximum
  always_comb begin
    width_ext  = LW_W'(line_width_r);
    height_ext = LH_W'(frame_height_r);
    if (width_ext == '0)                 width_eff = LW_W'(1);
    else if (width_ext > LW_W'(MAX_WIDTH)) width_eff = LW_W'(MAX_WIDTH);
    else                                 width_eff = width_ext;
    if (height_ext == '0)                  height_eff = LH_W'(1);
    else if (height_ext > LH_W'(MAX_HEIGHT)) height_eff = LH_W'(MAX_HEIGHT);
    else                                   height_eff = height_ext;
    line_last   = LW_W'(SYNC_WORDS) + width_eff - LW_W'(1);
    height_last = height_eff - LH_W'(1);
  end

  // Handshake: output register frees on drain
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign start     = in_tuser;

  assign acc_ctrl.clear = in_acc && start;
  assign acc_ctrl.step  = in_acc && (start || !frame_done_r);

  p10lu_bit_acc u_bit_acc (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (acc_ctrl),
    .raw_byte (in_tdata),
    .acc_out  (acc_out)
  );

  // Line and frame counters, result formation
  always_comb begin
    wil_cur        = start ? '0 : wil_r;
    line_idx_cur   = start ? '0 : line_idx_r;
    frame_done_cur = start ? 1'b0 : frame_done_r;
    wil_nxt        = wil_r;
    line_idx_nxt   = line_idx_r;
    frame_done_nxt = frame_done_r;
    emit           = 1'b0;
    out_pix_nxt    = acc_out.word[WORD_W-1 -: PIX_W];
    out_eol_nxt    = 1'b0;
    out_eof_nxt    = 1'b0;
    if (in_acc) begin
      wil_nxt        = wil_cur;
      line_idx_nxt   = line_idx_cur;
      frame_done_nxt = frame_done_cur;
      if (!frame_done_cur && acc_out.word_ok) begin
        if (LW_W'(wil_cur) < LW_W'(SYNC_WORDS)) begin
          // sync word: dropped
          wil_nxt = wil_cur + WIL_W'(1);
        end else begin
          emit = 1'b1;
          if (LW_W'(wil_cur) >= line_last) begin
            out_eol_nxt = 1'b1;
            wil_nxt     = '0;
            if (LH_W'(line_idx_cur) >= height_last) begin
              out_eof_nxt    = 1'b1;
              line_idx_nxt   = '0;
              frame_done_nxt = 1'b1;
            end else begin
              line_idx_nxt = line_idx_cur + LI_W'(1);
            end
          end else begin
            wil_nxt = wil_cur + WIL_W'(1);
          end
        end
      end
    end
  end

  always_comb begin
    priority if (in_acc && emit) out_valid_nxt = 1'b1;
    else if (out_tready)         out_valid_nxt = 1'b0;
    else                         out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wil_r        <= '0;
      line_idx_r   <= '0;
      frame_done_r <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      wil_r        <= wil_nxt;
      line_idx_r   <= line_idx_nxt;
      frame_done_r <= frame_done_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      out_pix_r <= out_pix_nxt;
      out_eol_r <= out_eol_nxt;
      out_eof_r <= out_eof_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pix_r;
  assign out_tlast  = out_eol_r;
  assign out_tuser  = out_eof_r;

  // Checks
  a_eof_idles: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && emit && out_eof_nxt) |=> frame_done_r)
    else $error("frame end did not put the block to idle");

  a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && frame_done_r && !in_tuser) |=>
      (out_tvalid == $past(out_tvalid && !out_tready)))
    else $error("result produced while waiting for frame start");

  a_wil_bound: assert property (@(posedge clk) disable iff (!rst_n)
    LW_W'(wil_r) <= LW_W'(SYNC_WORDS + MAX_WIDTH - 1))
    else $error("word counter ran past the longest line");

endmodule

>>> test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import p10lu_pkg::*;

  localparam int unsigned MAX_W      = 2048;
  localparam int unsigned MAX_H      = 2048;
  localparam int unsigned SYNC_W     = 2;
  localparam int unsigned CYCLE_CAP  = 500000;
  localparam int unsigned RANDOM_LEN = 200;

  // one unpacked pixel as it leaves the block
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             eol;
    logic             eof;
  } pixel_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [BYTE_W-1:0] in_tdata = '0;   // [7:0] raw_byte
  logic              in_tuser = 1'b0; // [0] frame_start
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [PIX_W-1:0]  out_tdata;       // [7:0] pixel
  logic              out_tlast;       // end_of_line
  logic              out_tuser;       // [0] end_of_frame
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [APB_AW-1:0] cfg_paddr = '0;
  logic [APB_DW-1:0] cfg_pwdata = '0;
  logic [APB_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  packed_10bit_line_unpacker dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state, mirrors the block after reset
  logic [CFG_W-1:0]  width_reg = CFG_W'(752);
  logic [CFG_W-1:0]  height_reg = CFG_W'(480);
  logic [PEND_W-1:0] pend_bits = '0;
  logic [PCNT_W-1:0] pend_cnt = '0;
  logic [CFG_W-1:0]  word_pos = '0;
  logic [CFG_W-1:0]  line_pos = '0;
  logic              awaiting_start = 1'b1;

  pixel_t      pixels_due[$];
  int unsigned mismatches = 0;
  int unsigned cycle_cnt = 0;

  // traffic shaping knobs
  bit          tx_quiet = 1'b0;
  bit          rx_quiet = 1'b0;
  int unsigned hold_len = 0;

  function automatic int unsigned eff_size(logic [CFG_W-1:0] v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // bytes covering a whole frame of w x h pixels
  function automatic int unsigned frame_len(int unsigned w, int unsigned h);
    return (h * (SYNC_W + w) * WORD_W + 7) / 8;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH @%0t: %s", $realtime, what);
  endtask

  // bit accumulator + line/frame counters for one accepted byte
  task automatic unpack_byte(input logic [BYTE_W-1:0] b, input logic fs);
    logic [PEND_W+BYTE_W-1:0] acc;
    logic [WORD_W-1:0]        word;
    int unsigned              cnt;
    int unsigned              w;
    int unsigned              h;
    pixel_t                   px;
    if (fs) begin
      pend_bits = '0;
      pend_cnt = '0;
      word_pos = '0;
      line_pos = '0;
      awaiting_start = 1'b0;
    end
    if (awaiting_start) return;
    acc = {pend_bits, b};
    cnt = pend_cnt + BYTE_W;
    if (cnt < WORD_W) begin
      pend_bits = acc[PEND_W-1:0];
      pend_cnt = PCNT_W'(cnt);
      return;
    end
    word = WORD_W'(acc >> (cnt - WORD_W));
    cnt = cnt - WORD_W;
    pend_bits = acc[PEND_W-1:0] & PEND_W'((1 << cnt) - 1);
    pend_cnt = PCNT_W'(cnt);
    // sync words are dropped
    if (word_pos < SYNC_W) begin
      word_pos++;
      return;
    end
    w = eff_size(width_reg, MAX_W);
    h = eff_size(height_reg, MAX_H);
    px.pixel = word[WORD_W-1:2];
    px.eol = 1'b0;
    px.eof = 1'b0;
    if (word_pos >= SYNC_W + w - 1) begin
      px.eol = 1'b1;
      word_pos = '0;
      if (line_pos >= h - 1) begin
        px.eof = 1'b1;
        line_pos = '0;
        awaiting_start = 1'b1;
      end else begin
        line_pos++;
      end
    end else begin
      word_pos++;
    end
    pixels_due.push_back(px);
  endtask

  // one byte request on the input stream, with a random gap before it
  task automatic push_byte(input logic [BYTE_W-1:0] b, input logic fs);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tuser <= fs;
    do @(posedge clk); while (!in_tready);
    unpack_byte(b, fs);
  endtask

  // first byte carries frame_start; fill < 0 means random content
  task automatic send_frame(input int unsigned n, input int fill);
    for (int unsigned i = 0; i < n; i++)
      push_byte(fill < 0 ? BYTE_W'($urandom) : BYTE_W'(fill), i == 0);
  endtask

  // stop sending and let every outstanding pixel drain
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write, then read back
  task automatic write_reg(input cfg_reg_t r, input logic [CFG_W-1:0] v);
    logic [APB_DW-1:0] want;
    want = APB_DW'(v);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= APB_AW'(r) << 2;
    cfg_pwdata <= want;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (r == REG_LINE_WIDTH) width_reg = v;
    else height_reg = v;
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== want)
      flag_mismatch($sformatf("readback %s: expected %h got %h", r.name(), want, cfg_prdata));
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // receiver: random stall per pixel, long hold on request
  initial begin
    int unsigned n;
    forever begin
      if (hold_len > 0) begin
        out_tready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end
      n = rx_quiet ? 0 : $urandom_range(0, 10);
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready) && hold_len == 0);
    end
  end

  // result checker
  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.pixel = out_tdata;
      got.eol = out_tlast;
      got.eof = out_tuser;
      if (pixels_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected pixel %h eol %b eof %b",
                                got.pixel, got.eol, got.eof));
      end else begin
        want = pixels_due.pop_front();
        if (got.pixel !== want.pixel || got.eol !== want.eol || got.eof !== want.eof)
          flag_mismatch($sformatf("pixel %h/%h eol %b/%b eof %b/%b (expected/actual)",
                                  want.pixel, got.pixel, want.eol, got.eol,
                                  want.eof, got.eof));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("testbench failed");
      $finish;
    end
  end

  // bytes before any frame_start are dropped
  task automatic test_idle_after_reset();
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    repeat (4) push_byte(BYTE_W'($urandom), 1'b0);
    settle();
  endtask

  // a 4 x 1 frame, constant fills, frame restart mid-frame
  task automatic test_extreme_bytes();
    write_reg(REG_LINE_WIDTH, 12'd4);
    write_reg(REG_FRAME_HEIGHT, 12'd1);
    send_frame(frame_len(4, 1), 8'hFF);
    send_frame(frame_len(4, 1), 8'h00);
    push_byte(8'hA5, 1'b0);  // idle, ignored
    send_frame(5, -1);
    send_frame(frame_len(4, 1), -1);
    settle();
  endtask

  // zero and oversized register values clamp
  task automatic test_register_clamps();
    write_reg(REG_LINE_WIDTH, 12'd0);
    write_reg(REG_FRAME_HEIGHT, 12'd0);
    send_frame(frame_len(1, 1), -1);
    send_frame(frame_len(1, 1), 8'hFF);
    settle();
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    write_reg(REG_LINE_WIDTH, 12'd2048);
    write_reg(REG_FRAME_HEIGHT, 12'd2048);
    send_frame(40, -1);
    settle();
    // oversized width: the line stays open over a short stretch
    write_reg(REG_LINE_WIDTH, 12'hFFF);
    write_reg(REG_FRAME_HEIGHT, 12'd1);
    send_frame(40, -1);
    settle();
    write_reg(REG_LINE_WIDTH, 12'd4);
    write_reg(REG_FRAME_HEIGHT, 12'hFFF);
    send_frame(frame_len(4, 3), -1);
    settle();
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // line boundaries at every bit offset
  task automatic test_odd_widths();
    write_reg(REG_FRAME_HEIGHT, 12'd3);
    write_reg(REG_LINE_WIDTH, 12'd5);
    send_frame(frame_len(5, 3), -1);
    settle();
    write_reg(REG_LINE_WIDTH, 12'd6);
    send_frame(frame_len(6, 3), -1);
    settle();
    write_reg(REG_LINE_WIDTH, 12'd7);
    send_frame(frame_len(7, 3), -1);
    settle();
  endtask

  // shrink width and height while a frame is in progress
  task automatic test_change_mid_frame();
    write_reg(REG_LINE_WIDTH, 12'd8);
    write_reg(REG_FRAME_HEIGHT, 12'd3);
    send_frame(20, -1);
    settle();
    write_reg(REG_LINE_WIDTH, 12'd2);
    for (int i = 0; i < 6; i++) push_byte(BYTE_W'($urandom), 1'b0);
    settle();
    write_reg(REG_FRAME_HEIGHT, 12'd1);
    for (int i = 0; i < 12; i++) push_byte(BYTE_W'($urandom), 1'b0);
    settle();
  endtask

  // receiver holds off long enough to stall the input
  task automatic test_output_stall();
    write_reg(REG_LINE_WIDTH, 12'd12);
    write_reg(REG_FRAME_HEIGHT, 12'd4);
    tx_quiet = 1'b1;
    hold_len = 200;
    send_frame(frame_len(12, 4), -1);
    tx_quiet = 1'b0;
    settle();
  endtask

  // mostly well-formed frames, some truncated frames and noise
  task automatic test_random_traffic();
    int unsigned done_items;
    int unsigned len;
    int unsigned n;
    int unsigned kind;
    done_items = 0;
    while (done_items < RANDOM_LEN) begin
      if ($urandom_range(0, 4) == 0) begin
        settle();
        write_reg(REG_LINE_WIDTH, CFG_W'($urandom_range(0, 20)));
        write_reg(REG_FRAME_HEIGHT, CFG_W'($urandom_range(0, 4)));
      end
      tx_quiet = ($urandom_range(0, 4) == 0);
      rx_quiet = ($urandom_range(0, 4) == 0);
      len = frame_len(eff_size(width_reg, MAX_W), eff_size(height_reg, MAX_H));
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        send_frame(len, -1);
        done_items += len;
      end else if (kind == 7) begin
        n = $urandom_range(1, len - 1);
        send_frame(n, -1);
        done_items += n;
      end else if (kind == 8) begin
        repeat ($urandom_range(1, 6)) push_byte(BYTE_W'($urandom), 1'b0);
      end else begin
        n = $urandom_range(1, 12);
        repeat (n) push_byte(BYTE_W'($urandom), $urandom_range(0, 7) == 0);
        done_items += n;
      end
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    settle();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_after_reset();
    test_extreme_bytes();
    test_register_clamps();
    test_odd_widths();
    test_change_mid_frame();
    test_output_stall();
    test_random_traffic();
    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pixels_due.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

>>> packed_10bit_line_unpacker.f
rtl/core/p10lu_pkg.sv
rtl/core/p10lu_bit_acc.sv
rtl/core/packed_10bit_line_unpacker.sv
test/testbench.sv
